// ===== rtl/core/ctot_pkg.sv =====
// Shared constants for the coplanar triangle overlap test: coordinate defaults,
// hit codes and the table of the fourteen triangles whose areas are taken.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctot_pkg;

    localparam int DEF_COORD_WIDTH     = 16;
    localparam int DEF_COORD_FRAC_BITS = 8;
    localparam int TOL_WIDTH           = 32;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd1;

    localparam int VERT_WIDTH = 48;
    localparam int NUM_VERT   = 6;
    localparam int NUM_TRI    = 14;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [2:0] vidx_t;
    typedef logic [2:0] hit_t;

    localparam vidx_t V_A1 = 3'd0;
    localparam vidx_t V_A2 = 3'd1;
    localparam vidx_t V_A3 = 3'd2;
    localparam vidx_t V_B1 = 3'd3;
    localparam vidx_t V_B2 = 3'd4;
    localparam vidx_t V_B3 = 3'd5;

    localparam hit_t HIT_NONE  = 3'd0;
    localparam hit_t HIT_B_ONE = 3'd1;
    localparam hit_t HIT_B_TWO = 3'd2;
    localparam hit_t HIT_B_THR = 3'd3;
    localparam hit_t HIT_A_ONE = 3'd4;

    // Triangle slots: whole A, three sub-triangles per B vertex, whole B,
    // three sub-triangles for vertex one of A.
    localparam int TRI_AREA_A = 0;
    localparam int TRI_AREA_B = 10;
    localparam int TRI_A_SUB  = 11;

    localparam vidx_t TRI_P [NUM_TRI] = '{
        V_A1, V_B1, V_B1, V_B1, V_B2, V_B2, V_B2,
        V_B3, V_B3, V_B3, V_B1, V_A1, V_A1, V_A1};
    localparam vidx_t TRI_Q [NUM_TRI] = '{
        V_A2, V_A1, V_A1, V_A2, V_A1, V_A1, V_A2,
        V_A1, V_A1, V_A2, V_B2, V_B1, V_B1, V_B2};
    localparam vidx_t TRI_R [NUM_TRI] = '{
        V_A3, V_A2, V_A3, V_A3, V_A2, V_A3, V_A3,
        V_A2, V_A3, V_A3, V_B3, V_B2, V_B3, V_B3};

endpackage

`default_nettype wire

// ===== rtl/core/ctot_front.sv =====
// Front pipeline: unpacks the six vertices and forms the squared, scaled
// cross-product length of all fourteen triangles. Depends on ctot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctot_front import ctot_pkg::*; #(
    parameter int COORD_WIDTH     = DEF_COORD_WIDTH,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
    parameter int TW              = 72
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [VERT_WIDTH-1:0] vert [NUM_VERT],
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [NUM_TRI*TW-1:0]      out_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int VW3  = 3 * CW;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int MW   = PW + 1;
    localparam int H    = (MW + 1) / 2;
    localparam int HW   = MW - H;
    localparam int SQW  = 2 * MW;
    localparam int SW   = SQW + 2;
    localparam int SHL  = 32 - 4 * COORD_FRAC_BITS;
    localparam int LSH  = (SHL > 0) ? SHL : 0;
    localparam int RSH  = (SHL < 0) ? -SHL : 0;

    logic       adv;
    logic [4:0] v_reg;

    logic signed [DW-1:0] u_reg [NUM_TRI][3];
    logic signed [DW-1:0] w_reg [NUM_TRI][3];
    logic signed [PW-1:0] prod_reg [NUM_TRI][6];
    logic [MW-1:0]        mag_reg  [NUM_TRI][3];
    logic [2*H-1:0]       ll_reg   [NUM_TRI][3];
    logic [MW-1:0]        lh_reg   [NUM_TRI][3];
    logic [2*HW-1:0]      hh_reg   [NUM_TRI][3];
    logic [TW-1:0]        sq_reg   [NUM_TRI];

    logic signed [CW-1:0] crd [NUM_VERT][3];
    logic signed [DW-1:0] u_next [NUM_TRI][3];
    logic signed [DW-1:0] w_next [NUM_TRI][3];
    logic signed [MW-1:0] cr [NUM_TRI][3];
    logic [MW-1:0]        mag_next [NUM_TRI][3];
    logic [SW-1:0]        sum_s [NUM_TRI];
    logic [TW-1:0]        sq_next [NUM_TRI];

    assign adv       = !v_reg[4] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[4];

    always_comb begin
        for (int n = 0; n < NUM_VERT; n++) begin
            for (int k = 0; k < 3; k++) begin
                crd[n][k] = CW'(VW3'(vert[n]) >> ((2 - k) * CW));
            end
        end
        for (int t = 0; t < NUM_TRI; t++) begin
            for (int k = 0; k < 3; k++) begin
                u_next[t][k] = DW'(crd[TRI_Q[t]][k]) - DW'(crd[TRI_P[t]][k]);
                w_next[t][k] = DW'(crd[TRI_R[t]][k]) - DW'(crd[TRI_P[t]][k]);
            end
        end
    end

    always_comb begin
        for (int t = 0; t < NUM_TRI; t++) begin
            for (int k = 0; k < 3; k++) begin
                cr[t][k] = MW'(prod_reg[t][2*k]) - MW'(prod_reg[t][2*k+1]);
                mag_next[t][k] = cr[t][k][MW-1] ? MW'(-cr[t][k]) : MW'(cr[t][k]);
            end
        end
    end

    always_comb begin
        for (int t = 0; t < NUM_TRI; t++) begin
            sum_s[t] = '0;
            for (int k = 0; k < 3; k++) begin
                sum_s[t] = sum_s[t] + SW'((SQW'(hh_reg[t][k]) << (2 * H))
                                        + (SQW'(lh_reg[t][k]) << (H + 1))
                                        + SQW'(ll_reg[t][k]));
            end
            sq_next[t] = (TW'(sum_s[t] >> RSH)) << LSH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_reg <= u_next;
            w_reg <= w_next;
            for (int t = 0; t < NUM_TRI; t++) begin
                prod_reg[t][0] <= u_reg[t][1] * w_reg[t][2];
                prod_reg[t][1] <= u_reg[t][2] * w_reg[t][1];
                prod_reg[t][2] <= u_reg[t][2] * w_reg[t][0];
                prod_reg[t][3] <= u_reg[t][0] * w_reg[t][2];
                prod_reg[t][4] <= u_reg[t][0] * w_reg[t][1];
                prod_reg[t][5] <= u_reg[t][1] * w_reg[t][0];
                for (int k = 0; k < 3; k++) begin
                    ll_reg[t][k] <= mag_reg[t][k][H-1:0] * mag_reg[t][k][H-1:0];
                    lh_reg[t][k] <= mag_reg[t][k][H-1:0] * mag_reg[t][k][MW-1:H];
                    hh_reg[t][k] <= mag_reg[t][k][MW-1:H] * mag_reg[t][k][MW-1:H];
                end
            end
            mag_reg <= mag_next;
            sq_reg  <= sq_next;
        end
    end

    always_comb begin
        for (int t = 0; t < NUM_TRI; t++) begin
            out_data[t*TW +: TW] = sq_reg[t];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ctot_queue.sv =====
// Two-entry queue between the front and back pipelines.
// Depends on ctot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctot_queue import ctot_pkg::*; #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ctot_back.sv =====
// Back pipeline: one root bit per stage for all fourteen areas, then the
// area sums, the tolerance compare and the first-hit encode. Depends on ctot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctot_back import ctot_pkg::*; #(
    parameter int TW = 72
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [NUM_TRI*TW-1:0] in_data,
    input  wire logic [TOL_WIDTH-1:0] tol,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      out_overlap,
    output hit_t                      out_hit
);

    localparam int RW   = (TW + 1) / 2;
    localparam int RADW = 2 * RW;
    localparam int REMW = RW + 2;
    localparam int SUMW = RW + 1;
    localparam int CMPW = (SUMW > TOL_WIDTH) ? SUMW : TOL_WIDTH;

    logic adv;
    logic [RW-1:0] v_reg;
    logic          sv_reg;
    logic          m_valid_reg;
    logic          overlap_reg;
    hit_t          hit_reg;

    logic [RADW-1:0] rad_reg  [RW][NUM_TRI];
    logic [REMW-1:0] rem_reg  [RW][NUM_TRI];
    logic [RW-1:0]   root_reg [RW][NUM_TRI];

    logic [SUMW-1:0] sum_reg [4];
    logic [SUMW-1:0] whole_reg [2];

    assign adv         = !m_valid_reg || out_ready;
    assign in_ready    = adv;
    assign out_valid   = m_valid_reg;
    assign out_overlap = overlap_reg;
    assign out_hit     = hit_reg;

    for (genvar s = 0; s < RW; s++) begin : g_stage
        logic [RADW-1:0] rad_i  [NUM_TRI];
        logic [REMW-1:0] rem_i  [NUM_TRI];
        logic [RW-1:0]   root_i [NUM_TRI];
        logic [REMW-1:0] rem_t  [NUM_TRI];
        logic [REMW-1:0] trial  [NUM_TRI];

        always_comb begin
            for (int t = 0; t < NUM_TRI; t++) begin
                if (s == 0) begin
                    rad_i[t]  = RADW'(in_data[t*TW +: TW]);
                    rem_i[t]  = '0;
                    root_i[t] = '0;
                end else begin
                    rad_i[t]  = rad_reg[(s == 0) ? 0 : s - 1][t];
                    rem_i[t]  = rem_reg[(s == 0) ? 0 : s - 1][t];
                    root_i[t] = root_reg[(s == 0) ? 0 : s - 1][t];
                end
                rem_t[t] = {rem_i[t][REMW-3:0], rad_i[t][RADW-1 -: 2]};
                trial[t] = {root_i[t], 2'b01};
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int t = 0; t < NUM_TRI; t++) begin
                    rad_reg[s][t] <= rad_i[t] << 2;
                    if (rem_t[t] >= trial[t]) begin
                        rem_reg[s][t]  <= rem_t[t] - trial[t];
                        root_reg[s][t] <= {root_i[t][RW-2:0], 1'b1};
                    end else begin
                        rem_reg[s][t]  <= rem_t[t];
                        root_reg[s][t] <= {root_i[t][RW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // area = root / 2
    logic [SUMW-1:0] area [NUM_TRI];
    always_comb begin
        for (int t = 0; t < NUM_TRI; t++) begin
            area[t] = SUMW'(root_reg[RW-1][t] >> 1);
        end
    end

    logic [CMPW-1:0] diff [4];
    logic [CMPW-1:0] whole_x, sum_x;
    logic [3:0]      hit_v;
    hit_t            hit_next;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            whole_x = CMPW'(whole_reg[(j == 3) ? 1 : 0]);
            sum_x   = CMPW'(sum_reg[j]);
            diff[j] = (sum_x >= whole_x) ? sum_x - whole_x : whole_x - sum_x;
            hit_v[j] = diff[j] < CMPW'(tol);
        end
        if (hit_v[0]) begin
            hit_next = HIT_B_ONE;
        end else if (hit_v[1]) begin
            hit_next = HIT_B_TWO;
        end else if (hit_v[2]) begin
            hit_next = HIT_B_THR;
        end else if (hit_v[3]) begin
            hit_next = HIT_A_ONE;
        end else begin
            hit_next = HIT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            sv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v_reg       <= RW'({v_reg, in_valid});
            sv_reg      <= v_reg[RW-1];
            m_valid_reg <= sv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                sum_reg[j] <= area[1 + 3*j] + area[2 + 3*j] + area[3 + 3*j];
            end
            sum_reg[3]   <= area[TRI_A_SUB] + area[TRI_A_SUB + 1] + area[TRI_A_SUB + 2];
            whole_reg[0] <= area[TRI_AREA_A];
            whole_reg[1] <= area[TRI_AREA_B];
            overlap_reg  <= hit_next != HIT_NONE;
            hit_reg      <= hit_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/coplanar_triangle_overlap_test.sv =====
// Coplanar triangle overlap test: point-in-triangle by area sums.
// Input channel s_*: one triangle pair (six packed x,y,z Q8.8 vertices) per
//   transfer. Output channel m_*: m_overlap and m_hit_source (0 none, 1..3
//   vertex of B inside A, 4 vertex one of A inside B), one per pair, in order.
// cfg_wr_en/cfg_wr_data write area_tolerance (reset 1, units of 2^-16); write
//   it only while no pair is in flight.
// Throughput: one pair per cycle while m_ready is high. Path from input transfer
//   to m_valid: the transfer loads the first of five front stages that form
//   the squared cross-product lengths, then an entry in the queue, one root
//   bit per back stage (RW = (TW + 1) / 2 is the root width), then area sums
//   and the compare into the output register.
// A two-entry queue separates the front and the back. When m_ready is low
//   the back holds, the queue fills, and the front keeps taking pairs until
//   the queue is full and its last stage holds a pair; then s_ready drops.
//   Nothing is lost or repeated.
// Reset (aresetn low, synchronous) drops all pairs in flight and restores
//   the tolerance to 1.
`timescale 1ns / 1ps
`default_nettype none

module coplanar_triangle_overlap_test import ctot_pkg::*; #(
    parameter int COORD_WIDTH     = DEF_COORD_WIDTH,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [VERT_WIDTH-1:0] s_tri_a_vertex_one,
    input  wire logic [VERT_WIDTH-1:0] s_tri_a_vertex_two,
    input  wire logic [VERT_WIDTH-1:0] s_tri_a_vertex_three,
    input  wire logic [VERT_WIDTH-1:0] s_tri_b_vertex_one,
    input  wire logic [VERT_WIDTH-1:0] s_tri_b_vertex_two,
    input  wire logic [VERT_WIDTH-1:0] s_tri_b_vertex_three,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_overlap,
    output logic [2:0]                 m_hit_source,
    input  wire logic                  cfg_wr_en,
    input  wire logic [TOL_WIDTH-1:0]  cfg_wr_data
);

    localparam int SHL = 32 - 4 * COORD_FRAC_BITS;
    localparam int SW  = 4 * (COORD_WIDTH + 1) + 4;
    localparam int TW  = SW + ((SHL > 0) ? SHL : 0);
    localparam int QW  = NUM_TRI * TW;

    logic [TOL_WIDTH-1:0]  tol_reg;
    logic [VERT_WIDTH-1:0] vert [NUM_VERT];
    logic                  f_valid, f_ready, b_valid, b_ready;
    logic [QW-1:0]         f_data, b_data;
    hit_t                  hit;

    assign vert[V_A1] = s_tri_a_vertex_one;
    assign vert[V_A2] = s_tri_a_vertex_two;
    assign vert[V_A3] = s_tri_a_vertex_three;
    assign vert[V_B1] = s_tri_b_vertex_one;
    assign vert[V_B2] = s_tri_b_vertex_two;
    assign vert[V_B3] = s_tri_b_vertex_three;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    ctot_front #(
        .COORD_WIDTH     (COORD_WIDTH),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .TW              (TW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .vert      (vert),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    ctot_queue #(.W(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    ctot_back #(.TW(TW)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (b_valid),
        .in_ready    (b_ready),
        .in_data     (b_data),
        .tol         (tol_reg),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_overlap (m_overlap),
        .out_hit     (hit)
    );

    assign m_hit_source = hit;

    a_overlap_matches_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_overlap == (m_hit_source != HIT_NONE)))
        else $error("overlap flag disagrees with hit source");

    a_hit_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit_source == HIT_NONE || m_hit_source == HIT_B_ONE ||
                     m_hit_source == HIT_B_TWO || m_hit_source == HIT_B_THR ||
                     m_hit_source == HIT_A_ONE))
        else $error("hit source out of range");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_queue_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (f_valid && !f_ready) |-> b_valid)
        else $error("queue full but reports empty");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for coplanar_triangle_overlap_test: directed pairs, then
// random (mostly coplanar) and noise pairs, checked against stated verdicts or an area-sum predictor.
// Depends on ctot_pkg and the block under test.
`timescale 1ns / 1ps

module testbench;
    import ctot_pkg::*;

    localparam int CW     = DEF_COORD_WIDTH;
    localparam int FB     = DEF_COORD_FRAC_BITS;
    localparam int N_RAND = 1550;
    localparam int DRAIN  = 64;
    localparam longint LIMIT = 1000000;

    typedef logic [VERT_WIDTH-1:0] vert_t;
    typedef struct {
        logic overlap;
        hit_t hit;
    } verdict_t;
    typedef struct {
        vert_t    v [NUM_VERT];
        bit       typed;
        verdict_t want;
    } pair_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid, s_ready, m_valid, m_ready, m_overlap, cfg_wr_en;
    logic [2:0] m_hit_source;
    logic [TOL_WIDTH-1:0] cfg_wr_data;
    vert_t s_vert [NUM_VERT];

    logic [TOL_WIDTH-1:0] tol_model;
    verdict_t verdict_q [$];
    pair_row_t pair_rows [$];
    bit typed_now;
    verdict_t typed_want;
    int unsigned accepted_cnt, sent_cnt, fail_cnt;
    longint cycle_cnt;
    bit quiet;
    int stall_left;

    always #6 aclk = ~aclk;

    coplanar_triangle_overlap_test i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_tri_a_vertex_one   (s_vert[0]),
        .s_tri_a_vertex_two   (s_vert[1]),
        .s_tri_a_vertex_three (s_vert[2]),
        .s_tri_b_vertex_one   (s_vert[3]),
        .s_tri_b_vertex_two   (s_vert[4]),
        .s_tri_b_vertex_three (s_vert[5]),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_overlap            (m_overlap),
        .m_hit_source         (m_hit_source),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data)
    );

    function automatic vert_t pt(int x, int y, int z);
        logic [CW-1:0] xs, ys, zs;
        xs = x[CW-1:0];
        ys = y[CW-1:0];
        zs = z[CW-1:0];
        return {xs, ys, zs};
    endfunction

    function automatic longint coord(vert_t v, int k);
        logic signed [CW-1:0] raw;
        raw = v[(2-k)*CW +: CW];
        return longint'(raw);
    endfunction

    // Half the cross-product length, 16 fractional bits, rounded down.
    function automatic logic [63:0] tri_area(vert_t p, vert_t q, vert_t r);
        longint u [3], w [3], c [3];
        logic [127:0] sq, mag, cand;
        logic [63:0] root;
        int shift;
        sq = '0;
        for (int k = 0; k < 3; k++) begin
            u[k] = coord(q, k) - coord(p, k);
            w[k] = coord(r, k) - coord(p, k);
        end
        c[0] = u[1] * w[2] - u[2] * w[1];
        c[1] = u[2] * w[0] - u[0] * w[2];
        c[2] = u[0] * w[1] - u[1] * w[0];
        for (int k = 0; k < 3; k++) begin
            mag = (c[k] < 0) ? 128'(-c[k]) : 128'(c[k]);
            sq = sq + mag * mag;
        end
        shift = 32 - 4 * FB;
        if (shift > 0) sq = sq << shift;
        else if (shift < 0) sq = sq >> (-shift);
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = {64'b0, root | (64'd1 << b)};
            if (cand * cand <= sq) root = cand[63:0];
        end
        return root >> 1;
    endfunction

    function automatic bit vertex_inside(vert_t v, vert_t a, vert_t b, vert_t c,
                                         logic [63:0] whole, logic [TOL_WIDTH-1:0] tol);
        logic [63:0] total, diff;
        total = tri_area(v, a, b) + tri_area(v, a, c) + tri_area(v, b, c);
        diff = (total >= whole) ? total - whole : whole - total;
        return diff < 64'(tol);
    endfunction

    function automatic verdict_t predict_overlap(vert_t v [NUM_VERT],
                                                 logic [TOL_WIDTH-1:0] tol);
        verdict_t res;
        logic [63:0] area_a;
        area_a = tri_area(v[V_A1], v[V_A2], v[V_A3]);
        res.hit = HIT_NONE;
        if (vertex_inside(v[V_B1], v[V_A1], v[V_A2], v[V_A3], area_a, tol))
            res.hit = HIT_B_ONE;
        else if (vertex_inside(v[V_B2], v[V_A1], v[V_A2], v[V_A3], area_a, tol))
            res.hit = HIT_B_TWO;
        else if (vertex_inside(v[V_B3], v[V_A1], v[V_A2], v[V_A3], area_a, tol))
            res.hit = HIT_B_THR;
        else if (vertex_inside(v[V_A1], v[V_B1], v[V_B2], v[V_B3],
                               tri_area(v[V_B1], v[V_B2], v[V_B3]), tol))
            res.hit = HIT_A_ONE;
        res.overlap = (res.hit != HIT_NONE);
        return res;
    endfunction

    // Input transfers: queue the expected verdict.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (typed_now) verdict_q = {verdict_q, typed_want};
            else verdict_q = {verdict_q, predict_overlap(s_vert, tol_model)};
            accepted_cnt <= accepted_cnt + 1;
        end
    end

    // Output transfers: compare with the oldest verdict.
    always @(posedge aclk) begin
        verdict_t exp_v;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result overlap=%0b hit=%0d", $time,
                         m_overlap, m_hit_source);
                fail_cnt++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (m_overlap !== exp_v.overlap) begin
                    $display("%0t: overlap expected %0b actual %0b", $time,
                             exp_v.overlap, m_overlap);
                    fail_cnt++;
                end
                if (m_hit_source !== exp_v.hit) begin
                    $display("%0t: hit_source expected %0d actual %0d", $time,
                             exp_v.hit, m_hit_source);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("coplanar_triangle_overlap_test: mismatch");
            $finish;
        end
    end

    // Receiver: mostly ready, short stalls, a few long ones.
    always @(negedge aclk) begin
        int r;
        r = $urandom_range(99);
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (quiet || r < 80) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            stall_left <= (r < 96) ? $urandom_range(2) : $urandom_range(60, 20);
        end
    end

    task automatic send_pair(pair_row_t row);
        int r, gap;
        r = $urandom_range(99);
        gap = (quiet || r < 60) ? 0 : (r < 92) ? $urandom_range(3, 1) : $urandom_range(40, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_vert <= row.v;
        typed_now <= row.typed;
        typed_want <= row.want;
        s_valid <= 1'b1;
        sent_cnt++;
        do @(negedge aclk); while (accepted_cnt < sent_cnt);
    endtask

    task automatic drain_all();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (verdict_q.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic write_tolerance(logic [TOL_WIDTH-1:0] val);
        drain_all();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        tol_model = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_row(vert_t a1, vert_t a2, vert_t a3, vert_t b1, vert_t b2,
                           vert_t b3, bit typed, logic ov, hit_t hit);
        pair_row_t row;
        row.v = '{a1, a2, a3, b1, b2, b3};
        row.typed = typed;
        row.want.overlap = ov;
        row.want.hit = hit;
        pair_rows = {pair_rows, row};
    endtask

    function automatic int rand_c(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    // Weighted mix of three points: lies inside or on their triangle, up to the rounding of each coordinate.
    function automatic vert_t blend(vert_t p, vert_t q, vert_t r);
        int w0, w1, w2, tot;
        int c [3];
        w0 = $urandom_range(7);
        w1 = $urandom_range(7);
        w2 = $urandom_range(7) + 1;
        tot = w0 + w1 + w2;
        for (int k = 0; k < 3; k++)
            c[k] = int'((w0 * coord(p, k) + w1 * coord(q, k) + w2 * coord(r, k)) / tot);
        return pt(c[0], c[1], c[2]);
    endfunction

    function automatic pair_row_t random_pair();
        pair_row_t row;
        int r, span, zp;
        r = $urandom_range(99);
        span = ($urandom_range(9) == 0) ? 32767 : $urandom_range(2048, 16);
        zp = rand_c(span);
        row.typed = 1'b0;
        row.want = '{1'b0, HIT_NONE};
        if (r < 15) begin
            foreach (row.v[k]) row.v[k] = VERT_WIDTH'({$urandom, $urandom});
        end else begin
            for (int k = 0; k < NUM_VERT; k++)
                row.v[k] = pt(rand_c(span), rand_c(span), ($urandom_range(3) == 0) ? rand_c(span) : zp);
            if (r < 50) begin
                row.v[V_B1 + $urandom_range(2)] = blend(row.v[V_A1], row.v[V_A2], row.v[V_A3]);
            end else if (r < 70) begin
                row.v[V_A1] = blend(row.v[V_B1], row.v[V_B2], row.v[V_B3]);
            end else if (r < 80) begin
                row.v[V_B1 + $urandom_range(2)] = row.v[$urandom_range(2)];
            end
        end
        return row;
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) quiet = ($urandom_range(3) == 0);
            if (n == count / 2 && $urandom_range(1)) drain_all();
            send_pair(random_pair());
        end
        quiet = 0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        foreach (s_vert[k]) s_vert[k] = '0;
        typed_now = 1'b0;
        typed_want = '{1'b0, HIT_NONE};
        tol_model = TOL_RESET;
        accepted_cnt = 0;
        sent_cnt = 0;
        fail_cnt = 0;
        cycle_cnt = 0;
        quiet = 0;
        stall_left = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // All points equal: every area is zero, so vertex one of B hits.
        add_row('0, '0, '0, '0, '0, '0, 1'b1, 1'b1, HIT_B_ONE);
        add_row('1, '1, '1, '1, '1, '1, 1'b1, 1'b1, HIT_B_ONE);
        add_row(pt(0, 0, 0), pt(256, 0, 0), pt(0, 256, 0),
                pt(64, 64, 0), pt(900, 900, 0), pt(-900, 0, 0), 1'b0, 1'b0, HIT_NONE);
        add_row(pt(0, 0, 0), pt(256, 0, 0), pt(0, 256, 0),
                pt(900, 900, 0), pt(32, 32, 0), pt(-900, 0, 0), 1'b0, 1'b0, HIT_NONE);
        add_row(pt(0, 0, 0), pt(256, 0, 0), pt(0, 256, 0),
                pt(900, 900, 0), pt(-900, 0, 0), pt(128, 0, 0), 1'b0, 1'b0, HIT_NONE);
        add_row(pt(10, 10, 0), pt(20, 10, 0), pt(10, 20, 0),
                pt(-500, -500, 0), pt(600, -500, 0), pt(-500, 600, 0), 1'b0, 1'b0, HIT_NONE);
        add_row(pt(0, 0, 0), pt(256, 0, 0), pt(0, 256, 0),
                pt(2000, 2000, 0), pt(3000, 2000, 0), pt(2000, 3000, 0), 1'b0, 1'b0, HIT_NONE);
        add_row(pt(32767, 32767, 32767), pt(-32768, -32768, -32768), pt(32767, -32768, 0),
                pt(-32768, 32767, 0), pt(0, 0, 0), pt(32767, 0, -32768), 1'b0, 1'b0, HIT_NONE);
        add_row(pt(-32768, 0, 0), pt(32767, 0, 0), pt(0, 32767, 0),
                pt(0, -32768, 0), pt(-32768, 32767, 0), pt(32767, -32768, 0), 1'b0, 1'b0, HIT_NONE);
        // Collinear A: degenerate, zero area.
        add_row(pt(0, 0, 0), pt(100, 100, 0), pt(200, 200, 0),
                pt(50, 50, 0), pt(300, 0, 0), pt(0, 300, 0), 1'b0, 1'b0, HIT_NONE);
        add_row(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_5555_AAAA,
                48'h5555_AAAA_5555, 48'hFFFF_0000_FFFF, 48'h0000_FFFF_0000, 1'b0, 1'b0, HIT_NONE);
        foreach (pair_rows[i]) send_pair(pair_rows[i]);
        random_phase(N_RAND / 5);

        // Zero tolerance: nothing can be inside.
        write_tolerance('0);
        send_pair('{v: '{default: '0}, typed: 1'b1, want: '{1'b0, HIT_NONE}});
        random_phase(N_RAND / 5);

        write_tolerance('1);
        send_pair('{v: '{default: '0}, typed: 1'b1, want: '{1'b1, HIT_B_ONE}});
        random_phase(N_RAND / 5);

        write_tolerance(32'd64);
        random_phase(N_RAND / 5);

        write_tolerance($urandom_range(65536));
        random_phase(N_RAND - 4 * (N_RAND / 5));

        drain_all();
        if (fail_cnt == 0) begin
            $display("coplanar_triangle_overlap_test: match");
        end else begin
            $display("coplanar_triangle_overlap_test: mismatch");
        end
        $finish;
    end

endmodule
